// ===== hdl/cti_pkg.sv =====
// ----------------------------------------------------------------------------
// cti_pkg
// Shared types and constants of the coverage threshold intervals block.
// ----------------------------------------------------------------------------
package cti_pkg;

  // default number of coverage counters
  localparam int unsigned MAX_BLOCK_DEF = 4096;

  // fixed field widths
  localparam int unsigned START_W  = 12;
  localparam int unsigned LEN_W    = 13;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned MINCOV_W = 8;
  localparam int unsigned BLEN_W   = 13;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_COVERAGE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH = 1'd1;

  // register reset values
  localparam logic [MINCOV_W-1:0] MIN_COVERAGE_RST = 8'd1;
  localparam logic [BLEN_W-1:0]   BLOCK_LENGTH_RST = 13'd4096;

  // item kinds
  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_SCAN = 1'b1;

  // controller states, one-hot
  typedef enum logic [4:0] {
    ST_CLEAR   = 5'b00001,
    ST_IDLE    = 5'b00010,
    ST_ADD     = 5'b00100,
    ST_ADD_WB  = 5'b01000,
    ST_SCAN_EV = 5'b10000
  } cti_state_e;

  // controller to datapath
  typedef struct packed {
    logic clr_step;
    logic add_load;
    logic add_step;
    logic scan_read;
    logic scan_commit;
  } cti_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic add_empty;
    logic add_last;
    logic scan_emit;
    logic slot_free;
  } cti_sts_t;

endpackage

// ===== hdl/cti_item_if.sv =====
// ----------------------------------------------------------------------------
// cti_item_if
// Input channel: one add or scan item per beat.
// ----------------------------------------------------------------------------
interface cti_item_if;
  import cti_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [START_W-1:0]   seg_start_in;
  logic [LEN_W-1:0]     seg_length_in;

  modport source (output valid, kind, seg_start_in, seg_length_in, input ready);
  modport sink   (input valid, kind, seg_start_in, seg_length_in, output ready);
endinterface

// ===== hdl/cti_run_if.sv =====
// ----------------------------------------------------------------------------
// cti_run_if
// Output channel: one closed run per beat.
// ----------------------------------------------------------------------------
interface cti_run_if;
  import cti_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [START_W-1:0]   run_start;
  logic [LEN_W-1:0]     run_length;

  modport source (output valid, run_start, run_length, input ready);
  modport sink   (input valid, run_start, run_length, output ready);
endinterface

// ===== hdl/cti_ram.sv =====
// ----------------------------------------------------------------------------
// cti_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cti_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/cti_ctrl.sv =====
// ----------------------------------------------------------------------------
// cti_ctrl
// Controller: clearing pass, segment walk and scan sequencing.
// ----------------------------------------------------------------------------
module cti_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_kind_i,
  output logic              in_ready_o,
  input  cti_pkg::cti_sts_t sts_i,
  output cti_pkg::cti_cmd_t cmd_o
);
  import cti_pkg::*;

  cti_state_e state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_kind_i == KIND_SCAN) begin
            cmd_o.scan_read = 1'b1;
            state_d         = ST_SCAN_EV;
          end else begin
            cmd_o.add_load = 1'b1;
            if (!sts_i.add_empty) begin
              state_d = ST_ADD;
            end
          end
        end
      end
      ST_ADD: begin
        cmd_o.add_step = 1'b1;
        if (sts_i.add_last) begin
          state_d = ST_ADD_WB;
        end
      end
      ST_ADD_WB: begin
        state_d = ST_IDLE;
      end
      ST_SCAN_EV: begin
        // hold until the output register can take the run
        if (!sts_i.scan_emit || sts_i.slot_free) begin
          cmd_o.scan_commit = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/cti_dpath.sv =====
// ----------------------------------------------------------------------------
// cti_dpath
// Datapath: configuration, coverage count memory, run tracking and output
// register.
// ----------------------------------------------------------------------------
module cti_dpath #(
  parameter int unsigned MAX_BLOCK = cti_pkg::MAX_BLOCK_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cti_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [cti_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic [cti_pkg::START_W-1:0]       seg_start_i,
  input  logic [cti_pkg::LEN_W-1:0]         seg_length_i,
  input  cti_pkg::cti_cmd_t                 cmd_i,
  output cti_pkg::cti_sts_t                 sts_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [cti_pkg::START_W-1:0]       run_start_o,
  output logic [cti_pkg::LEN_W-1:0]         run_length_o
);
  import cti_pkg::*;

  localparam int unsigned AW = $clog2(MAX_BLOCK);
  localparam int unsigned NW = $clog2(MAX_BLOCK + 1);
  localparam int unsigned CW = (NW > BLEN_W) ? NW : BLEN_W;
  localparam int unsigned EW = CW + 1;

  // configuration registers
  logic [MINCOV_W-1:0] min_cov_q;
  logic [BLEN_W-1:0]   blen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_cov_q <= MIN_COVERAGE_RST;
      blen_q    <= BLOCK_LENGTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MIN_COVERAGE: min_cov_q <= cfg_wdata_i[MINCOV_W-1:0];
        REG_BLOCK_LENGTH: blen_q    <= cfg_wdata_i[BLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // effective block length, clamped to one and to the memory depth
  logic [CW-1:0] blen_ext;
  logic [CW-1:0] n_eff;

  assign blen_ext = CW'(blen_q);

  always_comb begin
    if (blen_q == '0) begin
      n_eff = CW'(1);
    end else if (blen_ext > CW'(MAX_BLOCK)) begin
      n_eff = CW'(MAX_BLOCK);
    end else begin
      n_eff = blen_ext;
    end
  end

  // segment end, clipped to the block
  logic [EW-1:0] seg_sum;
  logic [CW-1:0] seg_end;
  logic [CW-1:0] seg_start_ext;

  assign seg_start_ext = CW'(seg_start_i);
  assign seg_sum       = EW'(seg_start_i) + EW'(seg_length_i);
  assign seg_end       = (seg_sum > EW'(n_eff)) ? n_eff : seg_sum[CW-1:0];

  // walk pointer (also the clearing counter) and segment end
  logic [CW-1:0] ptr_q;
  logic [CW-1:0] end_q;
  logic [CW-1:0] ptr_inc;

  assign ptr_inc = ptr_q + CW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else if (cmd_i.add_load) begin
      ptr_q <= seg_start_ext;
    end else if (cmd_i.add_step || cmd_i.clr_step) begin
      ptr_q <= ptr_inc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_load) begin
      end_q <= seg_end;
    end
  end

  // pending read-modify-write of the walk
  logic          wb_pend_q;
  logic [AW-1:0] wb_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_pend_q <= 1'b0;
    end else begin
      wb_pend_q <= cmd_i.add_step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_step) begin
      wb_addr_q <= ptr_q[AW-1:0];
    end
  end

  // scan state
  logic [CW-1:0] scan_pos_q, scan_pos_d;
  logic          run_open_q, run_open_d;
  logic [CW-1:0] open_start_q, open_start_d;
  logic [CW-1:0] open_len_q, open_len_d;

  // coverage count memory
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [COUNT_W-1:0] ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [COUNT_W-1:0] ram_rdata;
  logic [COUNT_W-1:0] count_inc;

  assign count_inc = (ram_rdata == '1) ? ram_rdata : ram_rdata + COUNT_W'(1);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr_q[AW-1:0];
    ram_wdata = '0;
    if (cmd_i.clr_step) begin
      ram_we = 1'b1;
    end else if (wb_pend_q) begin
      ram_we    = 1'b1;
      ram_waddr = wb_addr_q;
      ram_wdata = count_inc;
    end else if (cmd_i.scan_commit) begin
      ram_we    = 1'b1;
      ram_waddr = scan_pos_q[AW-1:0];
    end
  end

  assign ram_re    = cmd_i.add_step || cmd_i.scan_read;
  assign ram_raddr = cmd_i.add_step ? ptr_q[AW-1:0] : scan_pos_q[AW-1:0];

  cti_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (MAX_BLOCK)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // run evaluation of the scanned position
  logic          last_pos;
  logic          qualify;
  logic          emit;
  logic [CW-1:0] new_start;
  logic [CW-1:0] new_len;
  logic [CW-1:0] emit_start;
  logic [CW-1:0] emit_len;

  assign last_pos  = (scan_pos_q + CW'(1)) >= n_eff;
  assign qualify   = ram_rdata >= min_cov_q;
  assign new_start = run_open_q ? open_start_q : scan_pos_q;
  assign new_len   = (run_open_q ? open_len_q : '0) + CW'(1);
  assign emit      = qualify ? last_pos : run_open_q;
  assign emit_start = qualify ? new_start : open_start_q;
  assign emit_len   = qualify ? new_len : open_len_q;

  always_comb begin
    scan_pos_d   = scan_pos_q;
    run_open_d   = run_open_q;
    open_start_d = open_start_q;
    open_len_d   = open_len_q;
    if (cmd_i.scan_commit) begin
      if (last_pos || !qualify) begin
        run_open_d   = 1'b0;
        open_start_d = '0;
        open_len_d   = '0;
      end else begin
        run_open_d   = 1'b1;
        open_start_d = new_start;
        open_len_d   = new_len;
      end
      scan_pos_d = last_pos ? '0 : scan_pos_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_pos_q   <= '0;
      run_open_q   <= 1'b0;
      open_start_q <= '0;
      open_len_q   <= '0;
    end else begin
      scan_pos_q   <= scan_pos_d;
      run_open_q   <= run_open_d;
      open_start_q <= open_start_d;
      open_len_q   <= open_len_d;
    end
  end

  // output register
  logic               out_valid_q;
  logic [START_W-1:0] run_start_q;
  logic [LEN_W-1:0]   run_len_q;
  logic               slot_free;
  logic               load_out;

  assign slot_free = !out_valid_q || out_ready_i;
  assign load_out  = cmd_i.scan_commit && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      run_start_q <= emit_start[START_W-1:0];
      run_len_q   <= emit_len[LEN_W-1:0];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign run_start_o  = run_start_q;
  assign run_length_o = run_len_q;

  // status to the controller
  assign sts_o.clr_last  = (ptr_q == CW'(MAX_BLOCK - 1));
  assign sts_o.add_empty = seg_start_ext >= seg_end;
  assign sts_o.add_last  = (ptr_inc == end_q);
  assign sts_o.scan_emit = emit;
  assign sts_o.slot_free = slot_free;

endmodule

// ===== hdl/coverage_threshold_intervals_core.sv =====
// An add item walks its clipped segment through the count memory at one
// position per cycle, and it skips the walk when nothing of it lies in the
// block. A scan item reads its position and is held only while it closes a
// run and the output register still holds an untaken one. The walk over
// the count memory, read-modify-write with its single read port, sets the
// add rate. After reset a clearing pass zeroes the count memory, during
// which no item is accepted; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
// coverage_threshold_intervals_core
// Per-position coverage counting with threshold run extraction.
// ----------------------------------------------------------------------------
module coverage_threshold_intervals_core #(
  parameter int unsigned MAX_BLOCK = cti_pkg::MAX_BLOCK_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  cti_item_if.sink                       item_i,
  cti_run_if.source                      run_o,
  input  logic                           cfg_we_i,
  input  logic [cti_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cti_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import cti_pkg::*;

  cti_cmd_t cmd;
  cti_sts_t sts;

  // sequencing
  cti_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_kind_i  (item_i.kind),
    .in_ready_o (item_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // counts, runs and output beat
  cti_dpath #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .seg_start_i  (item_i.seg_start_in),
    .seg_length_i (item_i.seg_length_in),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (run_o.valid),
    .out_ready_i  (run_o.ready),
    .run_start_o  (run_o.run_start),
    .run_length_o (run_o.run_length)
  );

endmodule
